@@ hw/rtl/npc_pkg.sv @@
package npc_pkg;

  // Array geometry
  localparam int unsigned NUM_BLOCKS      = 8;
  localparam int unsigned PAGES_PER_BLOCK = 8;
  localparam int unsigned STORE_DEPTH     = NUM_BLOCKS * PAGES_PER_BLOCK;
  localparam int unsigned ADDR_W          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Range limits at field width
  localparam logic [7:0] BLK_LIMIT = 8'(NUM_BLOCKS);
  localparam logic [7:0] PG_LIMIT  = 8'(PAGES_PER_BLOCK);

  // Erased page content
  localparam logic [31:0] EMPTY_WORD = 32'h0000_00ff;

  // Opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_PAGE  = 3'd1;
  localparam logic [2:0] ST_BAD_BLOCK = 3'd2;
  localparam logic [2:0] ST_NOT_SEQ   = 3'd3;
  localparam logic [2:0] ST_WRITTEN   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  block;
    logic [7:0]  page;
    logic [31:0] write_data;
    logic [31:0] write_spare;
  } npc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [31:0] read_spare;
  } npc_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;         // capture input item
    logic rd_prev;      // read page below target
    logic rd_cur;       // read target page
    logic sweep_init;   // clearing pass step
    logic sweep_erase;  // block erase step
    logic resp;         // load result, commit write
  } npc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic init_last;
    logic erase_last;
    logic erase_go;
    logic slot_free;
  } npc_sts_t;

endpackage

@@ hw/rtl/npc_ctrl.sv @@
module npc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  npc_pkg::npc_sts_t sts_i,
  output npc_pkg::npc_cmd_t cmd_o
);
  import npc_pkg::*;

  typedef enum logic [5:0] {
    S_INIT    = 6'b000001,
    S_IDLE    = 6'b000010,
    S_RD_PREV = 6'b000100,
    S_RD_CUR  = 6'b001000,
    S_ERASE   = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_init = 1'b1;
        if (sts_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD_PREV;
        end
      end
      S_RD_PREV: begin
        cmd_o.rd_prev = 1'b1;
        state_d       = S_RD_CUR;
      end
      S_RD_CUR: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = sts_i.erase_go ? S_ERASE : S_RESP;
      end
      S_ERASE: begin
        cmd_o.sweep_erase = 1'b1;
        if (sts_i.erase_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.slot_free) begin
          cmd_o.resp = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/npc_datapath.sv @@
module npc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npc_pkg::npc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output npc_pkg::npc_out_t out_data_o,
  input  npc_pkg::npc_cmd_t cmd_i,
  output npc_pkg::npc_sts_t sts_o
);
  import npc_pkg::*;

  npc_in_t             item_q;
  npc_out_t            res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic                prev_empty_q;

  logic [31:0]         data_mem  [STORE_DEPTH];
  logic [31:0]         spare_mem [STORE_DEPTH];
  logic [31:0]         rd_data_q, rd_spare_q;

  logic [15:0]         base_full, cur_full, erase_full;
  logic [ADDR_W-1:0]   cur_addr, prev_addr, rd_addr, wr_addr;
  logic                page_ok, blk_ok, rng_ok, page_nz, cur_empty;
  logic                is_rw, wr_ok, rd_en, wr_en;
  logic [31:0]         wr_data, wr_spare;

  // Item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  // Address and range checks
  assign page_ok    = item_q.page < PG_LIMIT;
  assign blk_ok     = item_q.block < BLK_LIMIT;
  assign rng_ok     = page_ok && blk_ok;
  assign page_nz    = item_q.page != 8'd0;
  assign base_full  = 16'(item_q.block) * 16'(PAGES_PER_BLOCK);
  assign cur_full   = base_full + 16'(item_q.page);
  assign erase_full = base_full + 16'(cnt_q);
  assign cur_addr   = cur_full[ADDR_W-1:0];
  assign prev_addr  = cur_addr - ADDR_W'(1);
  assign is_rw      = (item_q.opcode == OP_READ) || (item_q.opcode == OP_WRITE);

  // Read address: out-of-range items read entry zero, result unused
  always_comb begin
    rd_addr = '0;
    if (rng_ok) begin
      rd_addr = (cmd_i.rd_prev && page_nz) ? prev_addr : cur_addr;
    end
  end
  assign rd_en = cmd_i.rd_prev || cmd_i.rd_cur;

  // Previous page emptiness, captured once its read returns
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_cur) prev_empty_q <= (rd_data_q == EMPTY_WORD);
  end
  assign cur_empty = (rd_data_q == EMPTY_WORD);

  // Result evaluation
  always_comb begin
    res_d = '0;
    wr_ok = 1'b0;
    res_d.status = ST_OK;
    if (is_rw) begin
      if (!page_ok) begin
        res_d.status = ST_BAD_PAGE;
      end else if (!blk_ok) begin
        res_d.status = ST_BAD_BLOCK;
      end else if (item_q.opcode == OP_READ) begin
        if (cur_empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.read_data  = rd_data_q;
          res_d.read_spare = rd_spare_q;
        end
      end else if (page_nz && prev_empty_q) begin
        res_d.status = ST_NOT_SEQ;
      end else if (!cur_empty) begin
        res_d.status = ST_WRITTEN;
      end else begin
        wr_ok = 1'b1;
      end
    end else if (item_q.opcode == OP_ERASE) begin
      if (!blk_ok) res_d.status = ST_BAD_BLOCK;
    end
  end

  // Write port: clearing pass, erase sweep, or page program
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = cur_addr;
    wr_data  = EMPTY_WORD;
    wr_spare = EMPTY_WORD;
    if (cmd_i.sweep_init) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
    end else if (cmd_i.sweep_erase) begin
      wr_en   = 1'b1;
      wr_addr = erase_full[ADDR_W-1:0];
    end else if (cmd_i.resp && wr_ok) begin
      wr_en    = 1'b1;
      wr_data  = item_q.write_data;
      wr_spare = item_q.write_spare;
    end
  end

  // Page store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      data_mem[wr_addr]  <= wr_data;
      spare_mem[wr_addr] <= wr_spare;
    end
    if (rd_en) begin
      rd_data_q  <= data_mem[rd_addr];
      rd_spare_q <= spare_mem[rd_addr];
    end
  end

  // Sweep counter
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.sweep_init) begin
      cnt_d = sts_o.init_last ? '0 : cnt_q + ADDR_W'(1);
    end else if (cmd_i.sweep_erase) begin
      cnt_d = sts_o.erase_last ? '0 : cnt_q + ADDR_W'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.resp) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) res_q <= res_d;
  end

  // Status to controller
  assign sts_o.init_last  = (cnt_q == ADDR_W'(STORE_DEPTH - 1));
  assign sts_o.erase_last = (cnt_q == ADDR_W'(PAGES_PER_BLOCK - 1));
  assign sts_o.erase_go   = (item_q.opcode == OP_ERASE) && blk_ok;
  assign sts_o.slot_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

@@ hw/rtl/nand_page_program_checker_core.sv @@
// NAND page program checker: holds NUM_BLOCKS x PAGES_PER_BLOCK pages of a 32-bit data
// and a 32-bit spare word each in a page store with one read and one write port, and
// answers each read, write, block erase or unused opcode with one status transfer.
// After reset a clearing pass writes 0xff into every entry (64 by default), one per
// cycle; in_ready_o stays low until it is done. A read or write then passes through
// two reads through the single store read port (page below and target page) and a
// response state that registers the result; an erase of an in-range block passes the
// same read states and then rewrites the block one entry per cycle. The response
// state waits while an earlier result is still untaken, and a new item is taken only
// once the previous one has left the response state. The result register lets the
// next item be accepted while the previous result waits for out_ready_i.
module nand_page_program_checker_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  npc_pkg::npc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output npc_pkg::npc_out_t out_data_o
);
  import npc_pkg::*;

  npc_cmd_t cmd;
  npc_sts_t sts;

  npc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  npc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // One item in flight: no accept in the cycle after a transfer in
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // Status codes stay within the defined set
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_EMPTY)
    else $error("undefined status code");

  // Read words are zero unless the item succeeded
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.read_data == '0 && out_data_o.read_spare == '0)
    else $error("nonzero read words on failed item");

  // A result is produced only after a response cycle, never right after accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without processing");

endmodule

@@ bench/npc_flash_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow copy of the page store and
// compares each result transfer with the oldest predicted one.
module npc_flash_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  npc_pkg::npc_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  npc_pkg::npc_out_t out_data_i,
  output int                fail_count_o,
  output int                outstanding_o
);
  import npc_pkg::*;

  logic [31:0] shadow_data  [STORE_DEPTH];
  logic [31:0] shadow_spare [STORE_DEPTH];
  npc_out_t    pending_resp_q [$];
  int          fails = 0;
  int          outstanding = 0;

  assign fail_count_o  = fails;
  assign outstanding_o = outstanding;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    $display("%0t: %s mismatch: got 0x%08h, expected 0x%08h", $time, what, got, want);
  endtask

  // Applies one operation to the shadow store and returns its status transfer
  function automatic npc_out_t predict_flash_op(input npc_in_t op);
    npc_out_t    res;
    int unsigned idx;
    int unsigned base;
    res  = '0;
    idx  = int'(op.block) * PAGES_PER_BLOCK + int'(op.page);
    base = int'(op.block) * PAGES_PER_BLOCK;
    case (op.opcode)
      OP_READ, OP_WRITE: begin
        // page range is checked ahead of block range
        if (op.page >= PG_LIMIT) begin
          res.status = ST_BAD_PAGE;
        end else if (op.block >= BLK_LIMIT) begin
          res.status = ST_BAD_BLOCK;
        end else if (op.opcode == OP_READ) begin
          if (shadow_data[idx] == EMPTY_WORD) begin
            res.status = ST_EMPTY;
          end else begin
            res.read_data  = shadow_data[idx];
            res.read_spare = shadow_spare[idx];
          end
        end else if (op.page != 8'd0 && shadow_data[idx-1] == EMPTY_WORD) begin
          res.status = ST_NOT_SEQ;
        end else if (shadow_data[idx] != EMPTY_WORD) begin
          res.status = ST_WRITTEN;
        end else begin
          shadow_data[idx]  = op.write_data;
          shadow_spare[idx] = op.write_spare;
        end
      end
      OP_ERASE: begin
        if (op.block >= BLK_LIMIT) begin
          res.status = ST_BAD_BLOCK;
        end else begin
          for (int unsigned p = 0; p < PAGES_PER_BLOCK; p++) begin
            shadow_data[base+p]  = EMPTY_WORD;
            shadow_spare[base+p] = EMPTY_WORD;
          end
        end
      end
      default: ; // unused opcode: no effect, status ok
    endcase
    return res;
  endfunction

  // Result side is checked before the new input is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    npc_out_t want;
    if (!rst_ni) begin
      pending_resp_q.delete();
      for (int i = 0; i < STORE_DEPTH; i++) begin
        shadow_data[i]  = EMPTY_WORD;
        shadow_spare[i] = EMPTY_WORD;
      end
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_resp_q.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(out_data_i.status), 32'd0);
        end else begin
          want = pending_resp_q.pop_front();
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(out_data_i.status), 32'(want.status));
          if (out_data_i.read_data !== want.read_data)
            report_mismatch("read_data", out_data_i.read_data, want.read_data);
          if (out_data_i.read_spare !== want.read_spare)
            report_mismatch("read_spare", out_data_i.read_spare, want.read_spare);
        end
      end
      if (in_valid_i && in_ready_i)
        pending_resp_q.push_back(predict_flash_op(in_data_i));
    end
    outstanding <= pending_resp_q.size();
  end

endmodule

@@ bench/tb_nand_page_program_checker_core.sv @@
`timescale 1ns / 100ps

module tb_nand_page_program_checker_core;
  import npc_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         TOTAL_OPS      = 1300;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  npc_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  npc_out_t out_item;

  int fail_count;
  int outstanding;
  int ops_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nand_page_program_checker_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_item)
  );

  npc_flash_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_item),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Result side backpressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else        out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("nand_page_program_checker_core test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic npc_in_t flash_op(input logic [1:0] opc, input logic [7:0] blk,
                                       input logic [7:0] pg, input logic [31:0] wd,
                                       input logic [31:0] ws);
    npc_in_t op;
    op.opcode      = opc;
    op.block       = blk;
    op.page        = pg;
    op.write_data  = wd;
    op.write_spare = ws;
    return op;
  endfunction

  // Mostly random data, now and then the erased pattern
  function automatic logic [31:0] rand_word();
    if ($urandom_range(15) == 0) return EMPTY_WORD;
    return $urandom;
  endfunction

  // Drive one item and hold it until the transfer
  task automatic push_flash_op(input npc_in_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ops_sent++;
  endtask

  // Unconstrained item, mostly in range
  function automatic npc_in_t rand_flash_op();
    logic [7:0] blk;
    logic [7:0] pg;
    blk = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                   : 8'($urandom_range(NUM_BLOCKS - 1));
    pg  = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                   : 8'($urandom_range(PAGES_PER_BLOCK - 1));
    return flash_op(2'($urandom_range(3)), blk, pg, rand_word(), $urandom);
  endfunction

  // Erase (usually), program pages in order, read back along the way
  task automatic program_block_burst();
    logic [7:0] blk;
    int         n;
    int         p;
    blk = 8'($urandom_range(NUM_BLOCKS - 1));
    if ($urandom_range(2) != 0)
      push_flash_op(flash_op(OP_ERASE, blk, 8'($urandom), $urandom, $urandom));
    n = $urandom_range(1, PAGES_PER_BLOCK);
    for (p = 0; p < n; p++) begin
      push_flash_op(flash_op(OP_WRITE, blk, 8'(p), rand_word(), $urandom));
      if ($urandom_range(3) == 0)
        push_flash_op(flash_op(OP_READ, blk, 8'($urandom_range(PAGES_PER_BLOCK - 1)),
                               $urandom, $urandom));
    end
    // rewrite of a programmed page, or a write to any page of the block
    if ($urandom_range(1) == 0)
      push_flash_op(flash_op(OP_WRITE, blk, 8'($urandom_range(n - 1)), rand_word(),
                             $urandom));
    else
      push_flash_op(flash_op(OP_WRITE, blk, 8'($urandom_range(PAGES_PER_BLOCK - 1)),
                             rand_word(), $urandom));
    push_flash_op(flash_op(OP_READ, blk, 8'($urandom_range(PAGES_PER_BLOCK - 1)),
                           $urandom, $urandom));
  endtask

  task automatic run_random_ops(input int target);
    while (ops_sent < target) begin
      if ($urandom_range(9) < 7) program_block_burst();
      else repeat ($urandom_range(1, 4)) push_flash_op(rand_flash_op());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct <= 7;
    recv_idle_pct <= 48;
    @(posedge clk);

    // Directed: ordering, rewrite, empty reads, range checks, erase, unused opcodes
    push_flash_op(flash_op(OP_READ,  8'd0, 8'd0, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_WRITE, 8'd0, 8'd1, 32'h1234_5678, 32'h0));
    push_flash_op(flash_op(OP_WRITE, 8'd0, 8'd0, 32'hdead_beef, 32'hcafe_f00d));
    push_flash_op(flash_op(OP_WRITE, 8'd0, 8'd0, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_READ,  8'd0, 8'd0, 32'h0, 32'h0));
    // programming the erased pattern leaves the page empty
    push_flash_op(flash_op(OP_WRITE, 8'd0, 8'd1, EMPTY_WORD, 32'h5555_aaaa));
    push_flash_op(flash_op(OP_READ,  8'd0, 8'd1, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_WRITE, 8'd0, 8'd2, 32'h1, 32'h1));
    push_flash_op(flash_op(OP_WRITE, 8'd0, 8'd1, 32'hffff_ffff, 32'h0));
    push_flash_op(flash_op(OP_READ,  8'd0, 8'd1, 32'h0, 32'h0));
    // bad page wins over bad block
    push_flash_op(flash_op(OP_READ,  8'hff, 8'hff, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_WRITE, 8'd0, 8'(PAGES_PER_BLOCK), 32'h0, 32'h0));
    push_flash_op(flash_op(OP_READ,  8'(NUM_BLOCKS), 8'(PAGES_PER_BLOCK - 1), 32'h0, 32'h0));
    push_flash_op(flash_op(OP_WRITE, 8'(NUM_BLOCKS - 1), 8'd0, 32'h0, 32'hffff_ffff));
    push_flash_op(flash_op(OP_READ,  8'(NUM_BLOCKS - 1), 8'd0, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_WRITE, 8'(NUM_BLOCKS - 1), 8'd1, 32'haaaa_5555,
                           32'h8000_0001));
    push_flash_op(flash_op(OP_READ,  8'(NUM_BLOCKS - 1), 8'd1, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_ERASE, 8'hff, 8'd0, 32'h0, 32'h0));
    // page field is don't-care on erase
    push_flash_op(flash_op(OP_ERASE, 8'd0, 8'hc8, 32'hffff_ffff, 32'hffff_ffff));
    push_flash_op(flash_op(OP_READ,  8'd0, 8'd0, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_UNUSED, 8'd0, 8'd0, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_UNUSED, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
    push_flash_op(flash_op(OP_READ,  8'(NUM_BLOCKS - 1), 8'd1, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_ERASE, 8'(NUM_BLOCKS - 1), 8'd0, 32'h0, 32'h0));
    push_flash_op(flash_op(OP_READ,  8'(NUM_BLOCKS - 1), 8'd0, 32'h0, 32'h0));

    // Random phases: slow receiver, slow sender, then full rate
    run_random_ops(TOTAL_OPS / 3);
    send_idle_pct <= 48;
    recv_idle_pct <= 7;
    run_random_ops(2 * TOTAL_OPS / 3);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_random_ops(TOTAL_OPS);
    in_valid <= 1'b0;

    // Drain outstanding results
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("nand_page_program_checker_core test passed");
    else
      $display("nand_page_program_checker_core test failed");
    $finish;
  end

endmodule
